@@ rtl/l48_pkg.sv @@
// ----------------------------------------------------------------------------
// Legacy 48-bit real conversion package
// Widths and constants shared by the converter pipeline.
// ----------------------------------------------------------------------------
package l48_pkg;
   localparam int MantBits = 37;
   localparam int PosBits  = 6;
   localparam int ExpBits  = 11;
   localparam int FracBits = 52;
   localparam int UnbBits  = 13;
   localparam logic [UnbBits-1:0] ExpShift = 13'd36;
   localparam logic [UnbBits-1:0] DblBias  = 13'd1023;
   localparam logic [UnbBits-1:0] DblExpMax = 13'd1024;

   typedef struct packed {
      logic                sign;
      logic                zero;
      logic [MantBits-1:0] mag;
      logic [ExpBits-1:0]  expo;
   } mag_type;
endpackage

@@ rtl/l48_norm.sv @@
// ----------------------------------------------------------------------------
// Leading-one search
// Returns the position of the highest set bit of the magnitude.
// ----------------------------------------------------------------------------
module l48_norm (
   input  logic [l48_pkg::MantBits-1:0] mag,
   output logic [l48_pkg::PosBits-1:0]  pos
);
   import l48_pkg::*;

   always_comb begin
      pos = '0;
      for (int i = 0; i < MantBits; i++) begin
         if (mag[i]) begin
            pos = PosBits'(i);
         end
      end
   end
endmodule

@@ rtl/legacy_48bit_real_to_double_core.sv @@
// ----------------------------------------------------------------------------
// Legacy 48-bit real to binary64 converter
// Three-stage pipeline: negate, leading-one search, shift and pack.
// ----------------------------------------------------------------------------
//  channel | direction | fields
//  req     | in        | six bytes of the legacy real
//  rsp     | out       | double_bits, overflowed
// One beat per cycle is accepted while req_stall is low. Reset clears only
// the stage valid bits. A stall on rsp holds a full stage only when all later
// stages are full too; an empty stage still takes a beat.
module legacy_48bit_real_to_double_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_low_low,
   input  logic [7:0]  req_byte_low_mid,
   input  logic [7:0]  req_byte_low_high,
   input  logic [7:0]  req_byte_high_low,
   input  logic [7:0]  req_byte_high_mid,
   input  logic [7:0]  req_byte_high_high,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_double_bits,
   output logic        rsp_overflowed
);
   import l48_pkg::*;

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;
   mag_type s1_ff, s1_in, s2_ff;
   logic [PosBits-1:0] pos2_ff, pos_w;
   logic [63:0] bits3_ff, bits3_in;
   logic ovf3_ff, ovf3_in;
   logic [MantBits-1:0] mant;

   assign en3 = !v3_ff || !rsp_stall;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;

   always_comb begin
      mant = {req_byte_high_high, req_byte_high_mid, req_byte_high_low,
              req_byte_low_mid[4:0], req_byte_low_low};
      s1_in.sign = mant[MantBits-1];
      s1_in.mag  = s1_in.sign ? (~mant + 1'b1) : mant;
      s1_in.zero = (mant == '0);
      s1_in.expo = {req_byte_low_high, req_byte_low_mid[7:5]};
   end

   l48_norm u_norm (.mag(s1_ff.mag), .pos(pos_w));

   always_comb begin
      logic [UnbBits-1:0]   unb;
      logic [MantBits+FracBits-1:0] sh;
      unb = UnbBits'(pos2_ff) + UnbBits'(s2_ff.expo) - ExpShift;
      sh = {{FracBits{1'b0}}, s2_ff.mag} << (FracBits - int'(pos2_ff));
      ovf3_in = 1'b0;
      if (s2_ff.zero) begin
         bits3_in = '0;
      end else if ($signed(unb) >= $signed(DblExpMax)) begin
         bits3_in = {s2_ff.sign, 11'h7ff, {FracBits{1'b0}}};
         ovf3_in = 1'b1;
      end else begin
         bits3_in = {s2_ff.sign, 11'(unb + DblBias), sh[FracBits-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
      if (en1) s1_ff <= s1_in;
      if (en2) begin
         s2_ff   <= s1_ff;
         pos2_ff <= pos_w;
      end
      if (en3) begin
         bits3_ff <= bits3_in;
         ovf3_ff  <= ovf3_in;
      end
   end

   assign rsp_valid       = v3_ff;
   assign rsp_double_bits = bits3_ff;
   assign rsp_overflowed  = ovf3_ff;

`ifndef SYNTHESIS
   a_ovf_inf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflowed |-> rsp_double_bits[62:52] == 11'h7ff)
      else $error("overflow without infinity");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && rsp_stall |=> v3_ff && $stable(bits3_ff))
      else $error("output lost under stall");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff)
      else $error("stall with an empty stage");
`endif
endmodule

@@ dv/tb_legacy_48bit_real_to_double_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Legacy 48-bit real to binary64 converter testbench
// Drives legacy reals, with directed edge values first and random values
// after that. Each value is converted to a double here and every response
// beat is compared with the oldest pending one. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_legacy_48bit_real_to_double_core;
   import l48_pkg::*;

   localparam int WatchdogLimit = 2000;

   typedef struct packed {
      logic [63:0] bits;
      logic        ovf;
   } dbl_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_low_low = '0;
   logic [7:0]  req_byte_low_mid = '0;
   logic [7:0]  req_byte_low_high = '0;
   logic [7:0]  req_byte_high_low = '0;
   logic [7:0]  req_byte_high_mid = '0;
   logic [7:0]  req_byte_high_high = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_double_bits;
   logic        rsp_overflowed;

   dbl_type pending_doubles[$];
   int      failures = 0;
   int      idle_cycles = 0;
   bit      calm = 1'b0;

   always #6 clock = ~clock;

   legacy_48bit_real_to_double_core i_dut (.*);

   function automatic dbl_type convert_real(input logic [47:0] raw);
      logic [MantBits-1:0] mant;
      logic [MantBits:0]   mag;
      logic [ExpBits-1:0]  expo;
      logic [63:0]         wide;
      logic                sign;
      int                  top;
      int                  unb;
      dbl_type             res;
      mant = {raw[47:40], raw[39:32], raw[31:24], raw[12:8], raw[7:0]};
      expo = {raw[23:16], raw[15:13]};
      sign = mant[MantBits-1];
      mag = sign ? ({1'b0, ~mant} + 38'd1) : {1'b0, mant};
      res = '0;
      if (mag != 0) begin
         top = 0;
         for (int i = 0; i <= MantBits; i++)
            if (mag[i]) top = i;
         unb = top + int'(expo) - 36;
         if (unb >= 1024) begin
            res.bits = {sign, 11'h7ff, 52'd0};
            res.ovf = 1'b1;
         end else begin
            wide = 64'(mag) << (52 - top);
            res.bits = {sign, 11'(unb + 1023), wide[51:0]};
         end
      end
      return res;
   endfunction

   // Bytes are packed as hh, hm, hl, lh, lm, ll from the top.
   task automatic send_real(input logic [47:0] raw);
      req_valid <= 1'b1;
      {req_byte_high_high, req_byte_high_mid, req_byte_high_low,
       req_byte_low_high, req_byte_low_mid, req_byte_low_low} <= raw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_doubles.push_back(convert_real(raw));
      if (!calm) begin
         while ($urandom_range(99) < 13) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   function automatic logic [47:0] pack_real(input logic [36:0] mant,
                                             input logic [10:0] expo);
      return {mant[36:13], expo[10:3], expo[2:0], mant[12:0]};
   endfunction

   always @(posedge clock) begin
      if (!reset)
         rsp_stall <= !calm && ($urandom_range(99) < 13);
   end

   always @(posedge clock) begin
      dbl_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_doubles.size() == 0) begin
            $display("%0t: unexpected beat %h ovf %b", $time, rsp_double_bits,
                     rsp_overflowed);
            failures++;
         end else begin
            want = pending_doubles.pop_front();
            if (rsp_double_bits !== want.bits) begin
               $display("%0t: double_bits expected %h actual %h", $time, want.bits,
                        rsp_double_bits);
               failures++;
            end
            if (rsp_overflowed !== want.ovf) begin
               $display("%0t: overflowed expected %b actual %b", $time, want.ovf,
                        rsp_overflowed);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic test_edges();
      send_real('0);
      send_real(pack_real('0, 11'h7ff));
      send_real(pack_real(37'h1_0000_0000, 11'h000));
      send_real(pack_real(37'h1_0000_0000, 11'h7ff));
      send_real(pack_real(37'h1_0000_0000, 11'd1023));
      send_real(pack_real(37'h0_0000_0001, 11'd0));
      send_real(pack_real(37'h0_0000_0001, 11'h7ff));
      send_real(pack_real(37'h1f_ffff_ffff, 11'd0));
      send_real(pack_real(37'h0f_ffff_ffff, 11'h7ff));
      send_real(pack_real(37'h0f_ffff_ffff, 11'd36));
      send_real(pack_real(37'h0f_ffff_ffff, 11'd1024));
      send_real(pack_real(37'h0f_ffff_ffff, 11'd1025));
      send_real(pack_real(37'h0_0000_0001, 11'd1059));
      send_real(pack_real(37'h0_0000_0001, 11'd1060));
      send_real(pack_real(37'h10_0000_0000, 11'd1023));
      send_real(pack_real(37'h10_0000_0000, 11'd1024));
      send_real(pack_real(37'h1f_ffff_ffff, 11'd1060));
      send_real(48'hffff_ffff_ffff);
      send_real(48'haaaa_aaaa_aaaa);
      send_real(48'h5555_5555_5555);
   endtask

   task automatic test_random();
      logic [36:0] mant;
      logic [10:0] expo;
      for (int n = 0; n < 600; n++) begin
         calm = (n >= 250 && n < 350);
         mant = 37'({$urandom(), $urandom()});
         case ($urandom_range(4))
            0: mant = mant >> $urandom_range(36);
            1: mant = ~(mant >> $urandom_range(36));
            default: ;
         endcase
         expo = $urandom_range(3) == 0 ? 11'($urandom_range(1000, 1100))
                                       : 11'($urandom());
         send_real(pack_real(mant, expo));
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edges();
      test_random();
      req_valid <= 1'b0;
      while (pending_doubles.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
